// ----- design/scws_pkg.sv -----
// Package: shared types, constants and command/status structs of the shunt current stats block
`default_nettype none
package scws_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CUR_W      = 28;
  localparam int SUM_W      = CUR_W + COUNT_BITS;
  localparam int SHUNT_W    = 10;
  localparam int DVS_W      = (COUNT_BITS > SHUNT_W) ? COUNT_BITS : SHUNT_W;
  localparam int QCNT_W     = $clog2(SUM_W);
  localparam int RAW_W      = 16;
  localparam int PROD_W     = 29;
  localparam int BUS_W      = 16;
  localparam int MV_W       = 17;
  localparam int PCT_W      = 7;
  localparam int OCNT_W     = 16;

  localparam int UA_SCALE   = 2500;
  localparam int PCT_SCALE  = 100;

  localparam logic [SHUNT_W-1:0]     SHUNT_RST  = SHUNT_W'(100);
  localparam logic signed [CUR_W-1:0] THRESH_RST = CUR_W'(5000);
  localparam logic signed [CUR_W-1:0] CUR_MAX    = {1'b0, {(CUR_W-1){1'b1}}};
  localparam logic signed [CUR_W-1:0] CUR_MIN    = {1'b1, {(CUR_W-1){1'b0}}};

  localparam logic CFG_SHUNT  = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  localparam logic [1:0] DSEL_CONV = 2'd0;
  localparam logic [1:0] DSEL_MEAN = 2'd1;
  localparam logic [1:0] DSEL_PCT  = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [RAW_W-1:0] shunt_raw;
    logic [BUS_W-1:0]        bus_raw;
  } in_t;

  typedef struct packed {
    logic [OCNT_W-1:0]       sample_count;
    logic signed [CUR_W-1:0] mean_ua;
    logic signed [CUR_W-1:0] min_ua;
    logic signed [CUR_W-1:0] max_ua;
    logic [MV_W-1:0]         bus_mv;
    logic [PCT_W-1:0]        below_pct;
  } out_t;

  typedef struct packed {
    logic       cap;
    logic       div_start;
    logic [1:0] div_sel;
    logic       upd_sample;
    logic       mean_save;
    logic       pct_save;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/scws_div.sv -----
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module scws_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [scws_pkg::SUM_W-1:0]   dividend,
  input  wire logic [scws_pkg::DVS_W-1:0]   divisor,
  output logic                              busy,
  output logic                              done,
  output logic [scws_pkg::SUM_W-1:0]        quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [scws_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [scws_pkg::SUM_W-1:0]        acc_r, acc_nxt;
  logic [scws_pkg::DVS_W-1:0]        rem_r, rem_nxt;
  logic [scws_pkg::DVS_W-1:0]        dvs_r, dvs_nxt;
  logic [scws_pkg::DVS_W:0]          trial;
  logic [scws_pkg::DVS_W:0]          diff;
  logic                              ge;

  always_comb begin
    trial    = {rem_r, acc_r[scws_pkg::SUM_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = scws_pkg::QCNT_W'(scws_pkg::SUM_W - 1);
      acc_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      acc_nxt = {acc_r[scws_pkg::SUM_W-2:0], ge};
      rem_nxt = ge ? diff[scws_pkg::DVS_W-1:0] : trial[scws_pkg::DVS_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = acc_r;

endmodule
`default_nettype wire

// ----- design/scws_dp.sv -----
// Datapath: config registers, window accumulators, conversion, divider and output register
`default_nettype none
module scws_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire scws_pkg::in_t                     in_data,
  input  wire logic                              cfg_wr,
  input  wire logic                              cfg_index,
  input  wire logic signed [scws_pkg::CUR_W-1:0] cfg_data,
  input  wire scws_pkg::cmd_t                    cmd,
  output scws_pkg::stat_t                        stat,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output scws_pkg::out_t                         out_data
);

  localparam int SUM_W = scws_pkg::SUM_W;
  localparam int CUR_W = scws_pkg::CUR_W;

  logic [scws_pkg::SHUNT_W-1:0]      shunt_r;
  logic signed [CUR_W-1:0]           thresh_r;
  logic signed [SUM_W-1:0]           sum_r;
  logic signed [CUR_W-1:0]           min_r;
  logic signed [CUR_W-1:0]           max_r;
  logic [scws_pkg::COUNT_BITS-1:0]   count_r;
  logic [scws_pkg::COUNT_BITS-1:0]   below_r;
  logic signed [scws_pkg::RAW_W-1:0] raw_r;
  logic [scws_pkg::BUS_W-1:0]        bus_r;
  logic                              neg_r, neg_nxt;
  logic signed [CUR_W-1:0]           mean_r;
  logic [scws_pkg::PCT_W-1:0]        pct_r;
  logic                              out_valid_r, out_valid_nxt;
  scws_pkg::out_t                    out_r, out_nxt;

  logic signed [scws_pkg::PROD_W-1:0] prod;
  logic [CUR_W-1:0]                  prod_mag;
  logic [SUM_W-1:0]                  sum_mag;
  logic [scws_pkg::SHUNT_W-1:0]      shunt_eff;
  logic [SUM_W-1:0]                  dvd;
  logic [scws_pkg::DVS_W-1:0]        dvs;
  logic [SUM_W-1:0]                  quot;
  logic signed [CUR_W-1:0]           qsigned;
  logic [scws_pkg::MV_W+1:0]         bus_x5;
  logic                              div_busy, div_done;

  always_comb begin
    prod      = $signed({{(scws_pkg::PROD_W-scws_pkg::RAW_W){raw_r[scws_pkg::RAW_W-1]}}, raw_r})
                * $signed(scws_pkg::PROD_W'(scws_pkg::UA_SCALE));
    prod_mag  = prod[scws_pkg::PROD_W-1] ? CUR_W'(-prod) : CUR_W'(prod);
    sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    shunt_eff = (shunt_r == '0) ? scws_pkg::SHUNT_W'(1) : shunt_r;
    unique case (cmd.div_sel)
      scws_pkg::DSEL_CONV: begin
        dvd     = SUM_W'(prod_mag);
        dvs     = scws_pkg::DVS_W'(shunt_eff);
        neg_nxt = prod[scws_pkg::PROD_W-1];
      end
      scws_pkg::DSEL_MEAN: begin
        dvd     = sum_mag;
        dvs     = scws_pkg::DVS_W'(count_r);
        neg_nxt = sum_r[SUM_W-1];
      end
      scws_pkg::DSEL_PCT: begin
        dvd     = SUM_W'(SUM_W'(below_r) * SUM_W'(scws_pkg::PCT_SCALE));
        dvs     = scws_pkg::DVS_W'(count_r);
        neg_nxt = 1'b0;
      end
      default: begin
        dvd     = '0;
        dvs     = scws_pkg::DVS_W'(1);
        neg_nxt = 1'b0;
      end
    endcase
  end

  scws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  assign qsigned = neg_r ? CUR_W'(-quot[CUR_W-1:0]) : quot[CUR_W-1:0];
  assign bus_x5  = {1'b0, bus_r, 2'b00} + {3'b000, bus_r};

  always_comb begin
    out_nxt              = out_r;
    out_nxt.sample_count = scws_pkg::OCNT_W'(count_r);
    out_nxt.mean_ua      = mean_r;
    out_nxt.min_ua       = min_r;
    out_nxt.max_ua       = max_r;
    out_nxt.bus_mv       = bus_x5[scws_pkg::MV_W+1:2];
    out_nxt.below_pct    = pct_r;
    out_valid_nxt        = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shunt_r     <= scws_pkg::SHUNT_RST;
      thresh_r    <= scws_pkg::THRESH_RST;
      sum_r       <= '0;
      min_r       <= scws_pkg::CUR_MAX;
      max_r       <= scws_pkg::CUR_MIN;
      count_r     <= '0;
      below_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (cfg_index)
          scws_pkg::CFG_SHUNT:  shunt_r  <= cfg_data[scws_pkg::SHUNT_W-1:0];
          scws_pkg::CFG_THRESH: thresh_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.upd_sample) begin
        sum_r   <= sum_r + SUM_W'(qsigned);
        count_r <= count_r + 1'b1;
        if (qsigned < min_r) begin
          min_r <= qsigned;
        end
        if (qsigned > max_r) begin
          max_r <= qsigned;
        end
        if (qsigned < thresh_r) begin
          below_r <= below_r + 1'b1;
        end
      end else if (cmd.load_out) begin
        sum_r   <= '0;
        min_r   <= scws_pkg::CUR_MAX;
        max_r   <= scws_pkg::CUR_MIN;
        count_r <= '0;
        below_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.cap) begin
      raw_r <= in_data.shunt_raw;
      bus_r <= in_data.bus_raw;
    end
    if (cmd.div_start) begin
      neg_r <= neg_nxt;
    end
    if (cmd.mean_save) begin
      mean_r <= qsigned;
    end
    if (cmd.pct_save) begin
      pct_r <= quot[scws_pkg::PCT_W-1:0];
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.count_full = &count_r;
  assign stat.div_busy   = div_busy;
  assign stat.div_done   = div_done;
  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule
`default_nettype wire

// ----- design/scws_ctrl.sv -----
// Controller: sequences sample conversion and window close through the shared divider
`default_nettype none
module scws_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_op,
  output logic                 in_stall,
  input  wire scws_pkg::stat_t stat,
  output scws_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CSTART = 4'd1;
  localparam logic [3:0] S_CDIV   = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_MSTART = 4'd4;
  localparam logic [3:0] S_MDIV   = 4'd5;
  localparam logic [3:0] S_PSTART = 4'd6;
  localparam logic [3:0] S_PDIV   = 4'd7;
  localparam logic [3:0] S_LOAD   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (in_op == scws_pkg::OP_SAMPLE) begin
            if (!stat.count_full) begin
              state_nxt = S_CSTART;
            end
          end else if (!stat.count_zero) begin
            state_nxt = S_MSTART;
          end
        end
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scws_pkg::DSEL_CONV;
        state_nxt     = S_CDIV;
      end
      S_CDIV: begin
        cmd.div_sel = scws_pkg::DSEL_CONV;
        if (stat.div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_sample = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scws_pkg::DSEL_MEAN;
        state_nxt     = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_sel = scws_pkg::DSEL_MEAN;
        if (stat.div_done) begin
          cmd.mean_save = 1'b1;
          state_nxt     = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scws_pkg::DSEL_PCT;
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_sel = scws_pkg::DSEL_PCT;
        if (stat.div_done) begin
          cmd.pct_save = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- design/shunt_current_window_stats.sv -----
// Top level: windowed shunt current min/max/mean statistics
// A sample is converted in the shared divider and added to the window before the next transfer.
// A close runs the shared 44-bit divider twice (mean, then percentage) and loads the result
// once the output register is free; the divider resolves one quotient bit per cycle.
// Samples keep transferring while a finished result waits in the output register.
// Synchronous active-low reset: window cleared, shunt 100 mOhm, threshold 5000 uA.
`default_nettype none
module shunt_current_window_stats (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire scws_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output scws_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic signed [scws_pkg::CUR_W-1:0] cfg_data
);

  scws_pkg::cmd_t  cmd;
  scws_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  scws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  scws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.count_zero)
    else $error("report loaded from an empty window");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while running");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid && stat.count_zero)
    else $error("load did not present result and clear window");
`endif

endmodule
`default_nettype wire

// ----- tb/shunt_current_window_stats_test.sv -----
// Testbench for shunt_current_window_stats: directed and random windows checked against a window-statistics predictor
`timescale 1ns / 100ps
module shunt_current_window_stats_test;
  import scws_pkg::*;

  localparam int MV_NUM         = 125;
  localparam int MV_DEN         = 100;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_SHUNT;
  logic signed [CUR_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  in_t pending_items[$];
  out_t expected_reports[$];
  int pushed_items = 0;
  int accepted_items = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [SHUNT_W-1:0] shunt_mohm = SHUNT_RST;
  logic signed [CUR_W-1:0] thresh_ua = THRESH_RST;
  longint win_sum;
  int win_min;
  int win_max;
  int unsigned win_count;
  int unsigned win_below;

  shunt_current_window_stats DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void clear_window();
    win_sum = 0;
    win_min = CUR_MAX;
    win_max = CUR_MIN;
    win_count = 0;
    win_below = 0;
  endfunction

  function automatic void predict_window(input in_t it);
    int divisor;
    int raw;
    int ua;
    out_t rep;
    if (it.op == OP_SAMPLE) begin
      if (win_count < (1 << COUNT_BITS) - 1) begin
        divisor = (shunt_mohm == '0) ? 1 : int'(shunt_mohm);
        raw = $signed(it.shunt_raw);
        ua = raw * UA_SCALE / divisor;
        win_sum += ua;
        win_count++;
        if (ua < win_min) win_min = ua;
        if (ua > win_max) win_max = ua;
        if (ua < int'(thresh_ua)) win_below++;
      end
    end else begin
      if (win_count != 0) begin
        rep.sample_count = OCNT_W'(win_count);
        rep.mean_ua = CUR_W'(win_sum / longint'(win_count));
        rep.min_ua = CUR_W'(win_min);
        rep.max_ua = CUR_W'(win_max);
        rep.bus_mv = MV_W'(int'(it.bus_raw) * MV_NUM / MV_DEN);
        rep.below_pct = PCT_W'(win_below * PCT_SCALE / win_count);
        expected_reports.push_back(rep);
      end
      clear_window();
    end
  endfunction

  task automatic check_report(input out_t got);
    out_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch($sformatf("result with none pending, count %0d", got.sample_count));
      return;
    end
    want = expected_reports.pop_front();
    if (got.sample_count !== want.sample_count)
      flag_mismatch($sformatf("sample_count %0d, want %0d", got.sample_count, want.sample_count));
    if (got.mean_ua !== want.mean_ua)
      flag_mismatch($sformatf("mean_ua %0d, want %0d", got.mean_ua, want.mean_ua));
    if (got.min_ua !== want.min_ua)
      flag_mismatch($sformatf("min_ua %0d, want %0d", got.min_ua, want.min_ua));
    if (got.max_ua !== want.max_ua)
      flag_mismatch($sformatf("max_ua %0d, want %0d", got.max_ua, want.max_ua));
    if (got.bus_mv !== want.bus_mv)
      flag_mismatch($sformatf("bus_mv %0d, want %0d", got.bus_mv, want.bus_mv));
    if (got.below_pct !== want.below_pct)
      flag_mismatch($sformatf("below_pct %0d, want %0d", got.below_pct, want.below_pct));
  endtask

  function automatic in_t sample_of(input int raw);
    in_t it;
    it.op = OP_SAMPLE;
    it.shunt_raw = RAW_W'(raw);
    it.bus_raw = BUS_W'($urandom);
    return it;
  endfunction

  function automatic in_t close_of(input int bus);
    in_t it;
    it.op = OP_CLOSE;
    it.shunt_raw = RAW_W'($urandom);
    it.bus_raw = BUS_W'(bus);
    return it;
  endfunction

  function automatic int pick_raw();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic queue_item(input in_t it);
    pending_items.push_back(it);
    pushed_items++;
  endtask

  task automatic queue_windows(input int budget);
    int queued;
    int len;
    queued = 0;
    while (queued < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        repeat (len) queue_item(sample_of(pick_raw()));
        queue_item(close_of($urandom_range(0, 65535)));
        queued += len + 1;
      end else begin
        queue_item(close_of($urandom_range(0, 65535)));
        queued += 1;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic signed [CUR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SHUNT) shunt_mohm = val[SHUNT_W-1:0];
    else thresh_ua = val;
  endtask

  // hold until every transfer is done and every result is in, then let trailing work finish
  task automatic settle_block();
    @(negedge clk);
    while (accepted_items != pushed_items || expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_report(out_data);
      if (in_valid && !in_stall) begin
        predict_window(in_data);
        accepted_items++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[shunt_current_window_stats] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int shunt;
    int thr;
    int span;
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(close_of(12345));
    queue_item(sample_of(32767));
    queue_item(sample_of(-32768));
    queue_item(sample_of(0));
    queue_item(sample_of(1));
    queue_item(sample_of(-1));
    queue_item(close_of(65535));
    queue_item(close_of(0));
    queue_item(sample_of(200));
    queue_item(sample_of(199));
    queue_item(close_of(0));
    queue_item(sample_of(-32768));
    queue_item(close_of(1));
    queue_item(sample_of(-1));
    queue_item(sample_of(-2));
    queue_item(close_of(80));
    queue_item(sample_of(32767));
    queue_item(close_of(32768));
    queue_item(close_of(65535));
    settle_block();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      case (p)
        0: begin shunt = 1; thr = CUR_MIN; end
        1: begin shunt = 0; thr = CUR_MAX; end
        2: begin shunt = 1023; thr = 0; end
        3: begin shunt = 1000; thr = -81920000; end
        4: begin shunt = 1000; thr = 81920000; end
        default: begin
          shunt = $urandom_range(0, 1023);
          span = 32768 * UA_SCALE / ((shunt == 0) ? 1 : shunt);
          thr = int'($urandom_range(0, 2 * span)) - span;
        end
      endcase
      write_reg(CFG_SHUNT, {(CUR_W-SHUNT_W)'($urandom), SHUNT_W'(shunt)});
      write_reg(CFG_THRESH, CUR_W'(thr));
      queue_windows(PHASE_ITEMS);
      settle_block();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[shunt_current_window_stats] OK");
    end else begin
      $display("[shunt_current_window_stats] ERROR");
    end
    $finish;
  end

endmodule

// ----- shunt_current_window_stats.f -----
design/scws_pkg.sv
design/scws_div.sv
design/scws_dp.sv
design/scws_ctrl.sv
design/shunt_current_window_stats.sv
tb/shunt_current_window_stats_test.sv
